// ----- rtl/core/delta_time_event_queue_unit_macros.svh -----
// assertion macros for the delta time event queue
`ifndef DELTA_TIME_EVENT_QUEUE_UNIT_MACROS_SVH
`define DELTA_TIME_EVENT_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define DTEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dteq check failed");

// next-cycle implication
`define DTEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dteq check failed");

`endif

// ----- rtl/core/dteq_pkg.sv -----
package dteq_pkg;

   localparam int ACTION_W  = 2;
   localparam int STATUS_W  = 2;
   localparam int TYPE_W    = 15;
   localparam int PAYLOAD_W = 64;
   localparam int DELAY_W   = 31;

   localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

   localparam logic [ACTION_W-1:0] ACT_POST  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_GET   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- rtl/core/delta_time_event_queue_unit.sv -----
// delta-list event queue, one request at a time, one response per request
// get unlinks the head, post links a free slot in place, flush unlinks every entry of the type
// get on an empty queue answers empty status, post on a full queue answers full status
// next request taken once the response register is loaded, walks one entry per cycle
// reset: queue empty, every slot on the free chain, next-link valid bits cleared,
// no clearing pass, request side stalled in reset, first request taken after reset drops
module delta_time_event_queue_unit #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dteq_pkg::ACTION_W-1:0]        req_action,
   input  logic [dteq_pkg::TYPE_W-1:0]          req_event_type,
   input  logic [dteq_pkg::PAYLOAD_W-1:0]       req_event_payload,
   input  logic [dteq_pkg::DELAY_W-1:0]         req_delay,
   input  logic                                 req_at_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dteq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [dteq_pkg::TYPE_W-1:0]          rsp_out_type,
   output logic [dteq_pkg::PAYLOAD_W-1:0]       rsp_out_payload,
   output logic [dteq_pkg::DELAY_W-1:0]         rsp_out_delay
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] NULL_PTR = PW'(QUEUE_DEPTH);

   localparam int TW = dteq_pkg::TYPE_W;
   localparam int LW = dteq_pkg::PAYLOAD_W;
   localparam int DW = dteq_pkg::DELAY_W;
   localparam int SW = dteq_pkg::STATUS_W;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_POST_FREE = 4'd1;
   localparam logic [3:0] S_POST_WALK = 4'd2;
   localparam logic [3:0] S_POST_LINK = 4'd3;
   localparam logic [3:0] S_POST_PREV = 4'd4;
   localparam logic [3:0] S_GET       = 4'd5;
   localparam logic [3:0] S_FL_WALK   = 4'd6;
   localparam logic [3:0] S_FL_END    = 4'd7;
   localparam logic [3:0] S_RESP      = 4'd8;

   // slot memories
   logic [TW-1:0] type_mem    [QUEUE_DEPTH];
   logic [LW-1:0] payload_mem [QUEUE_DEPTH];
   logic [DW-1:0] delay_mem   [QUEUE_DEPTH];
   logic [PW-1:0] next_mem    [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] next_vld_ff;

   logic [TW-1:0] rd_type_ff;
   logic [LW-1:0] rd_payload_ff;
   logic [DW-1:0] rd_delay_ff;
   logic [PW-1:0] rd_next_ff;
   logic          rd_nvld_ff;
   logic [IW-1:0] rd_idx_ff;
   logic [PW-1:0] rd_next;
   logic [PW-1:0] cur;

   logic [IW-1:0] rd_addr;
   logic          wr_tp_en;
   logic [IW-1:0] wr_tp_addr;
   logic          wr_dl_en;
   logic [IW-1:0] wr_dl_addr;
   logic [DW-1:0] wr_dl_data;
   logic          wr_nx_en;
   logic [IW-1:0] wr_nx_addr;
   logic [PW-1:0] wr_nx_data;

   logic [3:0]    state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] free_ff, free_in;
   logic [PW-1:0] prev_ff, prev_in;
   logic [PW-1:0] slot_ff, slot_in;
   logic [PW-1:0] link_ff, link_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic [DW-1:0] carry_ff, carry_in;
   logic          dirty_ff, dirty_in;
   logic          at_end_ff, at_end_in;
   logic [TW-1:0] type_ff, type_in;

   logic [SW-1:0] res_status_ff, res_status_in;
   logic [TW-1:0] res_type_ff, res_type_in;
   logic [LW-1:0] res_payload_ff, res_payload_in;
   logic [DW-1:0] res_delay_ff, res_delay_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_status_ff, rsp_status_in;
   logic [TW-1:0] rsp_type_ff, rsp_type_in;
   logic [LW-1:0] rsp_payload_ff, rsp_payload_in;
   logic [DW-1:0] rsp_delay_ff, rsp_delay_in;

   logic [DW:0]   flush_sum;
   logic [DW-1:0] flush_eff;

   assign rd_next   = rd_nvld_ff ? rd_next_ff : (PW'(rd_idx_ff) + PW'(1));
   assign cur       = PW'(rd_idx_ff);
   assign flush_sum = {1'b0, rd_delay_ff} + {1'b0, carry_ff};
   assign flush_eff = flush_sum[DW] ? dteq_pkg::DELAY_MAX : flush_sum[DW-1:0];

   always_ff @(posedge clock) begin
      if (wr_tp_en) begin
         type_mem[wr_tp_addr]    <= req_event_type;
         payload_mem[wr_tp_addr] <= req_event_payload;
      end
      if (wr_dl_en) begin
         delay_mem[wr_dl_addr] <= wr_dl_data;
      end
      if (wr_nx_en) begin
         next_mem[wr_nx_addr] <= wr_nx_data;
      end
      rd_type_ff    <= type_mem[rd_addr];
      rd_payload_ff <= payload_mem[rd_addr];
      rd_delay_ff   <= delay_mem[rd_addr];
      rd_next_ff    <= next_mem[rd_addr];
      rd_nvld_ff    <= next_vld_ff[rd_addr];
      rd_idx_ff     <= rd_addr;
   end

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      free_in        = free_ff;
      prev_in        = prev_ff;
      slot_in        = slot_ff;
      link_in        = link_ff;
      dist_in        = dist_ff;
      carry_in       = carry_ff;
      dirty_in       = dirty_ff;
      at_end_in      = at_end_ff;
      type_in        = type_ff;
      res_status_in  = res_status_ff;
      res_type_in    = res_type_ff;
      res_payload_in = res_payload_ff;
      res_delay_in   = res_delay_ff;
      rd_addr        = '0;
      wr_tp_en       = 1'b0;
      wr_tp_addr     = free_ff[IW-1:0];
      wr_dl_en       = 1'b0;
      wr_dl_addr     = rd_idx_ff;
      wr_dl_data     = '0;
      wr_nx_en       = 1'b0;
      wr_nx_addr     = rd_idx_ff;
      wr_nx_data     = '0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_type_in    = rsp_type_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_delay_in   = rsp_delay_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_status_in  = dteq_pkg::ST_DONE;
               res_type_in    = '0;
               res_payload_in = '0;
               res_delay_in   = '0;
               type_in        = req_event_type;
               dist_in        = req_delay;
               at_end_in      = req_at_end;
               prev_in        = NULL_PTR;
               carry_in       = '0;
               dirty_in       = 1'b0;
               unique case (req_action)
                  dteq_pkg::ACT_POST: begin
                     if (free_ff == NULL_PTR) begin
                        res_status_in = dteq_pkg::ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        wr_tp_en = 1'b1;
                        slot_in  = free_ff;
                        rd_addr  = free_ff[IW-1:0];
                        state_in = S_POST_FREE;
                     end
                  end
                  dteq_pkg::ACT_GET: begin
                     if (head_ff == NULL_PTR) begin
                        res_status_in = dteq_pkg::ST_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        rd_addr  = head_ff[IW-1:0];
                        state_in = S_GET;
                     end
                  end
                  dteq_pkg::ACT_FLUSH: begin
                     if (head_ff == NULL_PTR) begin
                        state_in = S_RESP;
                     end else begin
                        rd_addr  = head_ff[IW-1:0];
                        state_in = S_FL_WALK;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_POST_FREE: begin
            free_in = rd_next;
            if (head_ff == NULL_PTR) begin
               link_in  = NULL_PTR;
               state_in = S_POST_LINK;
            end else begin
               rd_addr  = head_ff[IW-1:0];
               state_in = S_POST_WALK;
            end
         end
         S_POST_WALK: begin
            if (!at_end_ff && (dist_ff < rd_delay_ff)) begin
               wr_dl_en   = 1'b1;
               wr_dl_data = rd_delay_ff - dist_ff;
               link_in    = cur;
               state_in   = S_POST_LINK;
            end else begin
               if (!at_end_ff) begin
                  dist_in = dist_ff - rd_delay_ff;
               end
               prev_in = cur;
               if (rd_next == NULL_PTR) begin
                  link_in  = NULL_PTR;
                  state_in = S_POST_LINK;
               end else begin
                  rd_addr = rd_next[IW-1:0];
               end
            end
         end
         S_POST_LINK: begin
            wr_dl_en   = 1'b1;
            wr_dl_addr = slot_ff[IW-1:0];
            wr_dl_data = at_end_ff ? '0 : dist_ff;
            wr_nx_en   = 1'b1;
            wr_nx_addr = slot_ff[IW-1:0];
            wr_nx_data = link_ff;
            if (prev_ff == NULL_PTR) begin
               head_in  = slot_ff;
               state_in = S_RESP;
            end else begin
               state_in = S_POST_PREV;
            end
         end
         S_POST_PREV: begin
            wr_nx_en   = 1'b1;
            wr_nx_addr = prev_ff[IW-1:0];
            wr_nx_data = slot_ff;
            state_in   = S_RESP;
         end
         S_GET: begin
            res_type_in    = rd_type_ff;
            res_payload_in = rd_payload_ff;
            res_delay_in   = rd_delay_ff;
            head_in        = rd_next;
            wr_nx_en       = 1'b1;
            wr_nx_data     = free_ff;
            free_in        = cur;
            state_in       = S_RESP;
         end
         S_FL_WALK: begin
            if (rd_type_ff == type_ff) begin
               // unlink, push on free chain, carry delay to successor
               carry_in   = flush_eff;
               wr_nx_en   = 1'b1;
               wr_nx_data = free_ff;
               free_in    = cur;
               if (prev_ff == NULL_PTR) begin
                  head_in = rd_next;
               end else begin
                  dirty_in = 1'b1;
               end
            end else begin
               if (carry_ff != '0) begin
                  wr_dl_en   = 1'b1;
                  wr_dl_data = flush_eff;
               end
               carry_in = '0;
               if (dirty_ff) begin
                  wr_nx_en   = 1'b1;
                  wr_nx_addr = prev_ff[IW-1:0];
                  wr_nx_data = cur;
               end
               dirty_in = 1'b0;
               prev_in  = cur;
            end
            if (rd_next == NULL_PTR) begin
               state_in = S_FL_END;
            end else begin
               rd_addr = rd_next[IW-1:0];
            end
         end
         S_FL_END: begin
            if (dirty_ff) begin
               wr_nx_en   = 1'b1;
               wr_nx_addr = prev_ff[IW-1:0];
               wr_nx_data = NULL_PTR;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_type_in    = res_type_ff;
               rsp_payload_in = res_payload_ff;
               rsp_delay_in   = res_delay_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_PTR;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         next_vld_ff  <= '0;
         dirty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         dirty_ff     <= dirty_in;
         if (wr_nx_en) begin
            next_vld_ff[wr_nx_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff        <= prev_in;
      slot_ff        <= slot_in;
      link_ff        <= link_in;
      dist_ff        <= dist_in;
      carry_ff       <= carry_in;
      at_end_ff      <= at_end_in;
      type_ff        <= type_in;
      res_status_ff  <= res_status_in;
      res_type_ff    <= res_type_in;
      res_payload_ff <= res_payload_in;
      res_delay_ff   <= res_delay_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_type_ff    <= rsp_type_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_delay_ff   <= rsp_delay_in;
   end

   assign req_stall       = reset || (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_type    = rsp_type_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_out_delay   = rsp_delay_ff;

endmodule

// ----- rtl/core/dteq_checker.sv -----
`include "delta_time_event_queue_unit_macros.svh"

module dteq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [dteq_pkg::STATUS_W-1:0]  rsp_status,
   input logic [dteq_pkg::TYPE_W-1:0]    rsp_out_type,
   input logic [dteq_pkg::PAYLOAD_W-1:0] rsp_out_payload,
   input logic [dteq_pkg::DELAY_W-1:0]   rsp_out_delay
);

   // stalled response holds
   `DTEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_out_type) && $stable(rsp_out_payload) && $stable(rsp_out_delay))

   // one request in flight
   `DTEQ_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // full or empty status carries no event
   `DTEQ_ASSERT_NOW(a_err_no_data, clock, reset, rsp_valid && (rsp_status != dteq_pkg::ST_DONE), (rsp_out_type == '0) && (rsp_out_payload == '0) && (rsp_out_delay == '0))

   `DTEQ_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, (rsp_status == dteq_pkg::ST_DONE) || (rsp_status == dteq_pkg::ST_FULL) || (rsp_status == dteq_pkg::ST_EMPTY))

endmodule

bind delta_time_event_queue_unit dteq_checker u_dteq_checker (.*);
